FILE: hw/rtl/hic_pkg.sv
// Shared types, constants and elaboration-time tap functions for the Hilbert IQ converter.
// No dependencies; every other module of the block imports this package.
`timescale 1ns / 1ps

package hic_pkg;

    localparam int HIC_TAPS   = 127;
    localparam int HIC_DELAY  = 63;
    localparam int SAMPLE_W   = 16;
    localparam int PROD_W     = 2 * SAMPLE_W;
    localparam int ROUND_SH   = 15;

    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1073741824;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DELAY,
        S_TAP,
        S_DRAIN,
        S_FINISH
    } t_state;

    // Tag that travels with a history read so the datapath knows what the word is.
    typedef struct packed {
        logic                       is_delay;
        logic                       is_tap;
        logic signed [SAMPLE_W-1:0] coef;
    } t_rd_tag;

    typedef struct packed {
        logic start;
        logic finish;
    } t_mac_ctl;

    // Restoring division, used only while the tap table is elaborated.
    function automatic logic [63:0] hic_udiv(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], num[b]};
            if (r >= {1'b0, den}) begin
                r    = r - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // cos(pi*a/m) in Q30 by a nine-term Taylor series (up to x^16), for 0 <= 2a <= m.
    function automatic logic signed [63:0] hic_cos_q30(input int unsigned a,
                                                      input int unsigned m);
        logic [63:0]        x;
        logic [63:0]        term;
        logic signed [63:0] sum;
        x    = hic_udiv(PI_Q30 * 64'(a), 64'(m));
        term = ONE_Q30;
        sum  = $signed(ONE_Q30);
        for (int k = 1; k <= 8; k++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = hic_udiv(term, 64'((2 * k - 1) * (2 * k)));
            if (k % 2 == 1) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        return sum;
    endfunction

    // Hamming-windowed Hilbert tap i of a taps-long filter, Q1.15.
    function automatic logic signed [SAMPLE_W-1:0] hic_tap_value(input int unsigned i,
                                                                 input int unsigned taps);
        int                 center;
        int                 n;
        int unsigned        m;
        int unsigned        j;
        int unsigned        absn;
        logic signed [63:0] c;
        logic signed [63:0] ws;
        logic [63:0]        w;
        logic [63:0]        num;
        logic [63:0]        den;
        logic [63:0]        mag;
        center = int'((taps - 1) >> 1);
        n      = int'(i) - center;
        m      = taps - 1;
        if (n == 0 || (n % 2) == 0) begin
            return '0;
        end
        j = (i <= m - i) ? i : m - i;
        if (4 * j <= m) begin
            c = hic_cos_q30(2 * j, m);
        end else begin
            c = -hic_cos_q30(m - 2 * j, m);
        end
        ws   = 64'sd57982058496 - 64'sd46 * c;
        w    = hic_udiv(ws, 64'd100);
        absn = (n < 0) ? int'(-n) : n;
        num  = w << 16;
        den  = PI_Q30 * 64'(absn);
        mag  = hic_udiv(num + (den >> 1), den);
        if (n < 0) begin
            return -(SAMPLE_W'(mag));
        end
        return SAMPLE_W'(mag);
    endfunction

endpackage

FILE: hw/rtl/hilbert_iq_converter_core.sv
// Top level of the Hilbert IQ converter: stream ports, history memory, sequencer and MAC.
// Depends on hic_pkg, hic_history_mem, hic_mac and hic_ctrl.
`timescale 1ns / 1ps

// Each real Q1.15 sample word in gives one complex word out. The real half is the
// sample received DELAY words earlier (DELAY taken modulo TAPS, so DELAY equal to
// TAPS returns the current sample); the imaginary half is a TAPS-tap Hamming-windowed
// Hilbert FIR, summed at full precision, rounded half up and saturated to Q1.15.
// Only the odd-offset taps are nonzero, so one shared multiply-accumulate unit walks
// them while reading the sample history memory one entry per cycle. After acceptance
// the sequencer steps through a delay read, the reads of the odd-offset taps (about
// TAPS/2 of them), a drain and a finish step that waits while the output is busy.
// The result sits in an output register, so the next sample is taken while a
// finished word still waits downstream. After reset a clearing pass zeroes every
// history entry, and no sample is accepted until it ends.

module hilbert_iq_converter_core #(
    parameter int TAPS  = hic_pkg::HIC_TAPS,
    parameter int DELAY = hic_pkg::HIC_DELAY
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [15:0] real_out, [31:16] imag_out
);
    import hic_pkg::*;

    localparam int K_W = $clog2(TAPS);

    logic                       mem_we;
    logic [K_W-1:0]             mem_waddr;
    logic signed [SAMPLE_W-1:0] mem_wdata;
    logic                       mem_re;
    logic [K_W-1:0]             mem_raddr;
    logic signed [SAMPLE_W-1:0] mem_rdata;
    t_rd_tag                    rd_tag;
    t_mac_ctl                   mac_ctl;
    logic                       out_busy;
    logic signed [SAMPLE_W-1:0] real_out;
    logic signed [SAMPLE_W-1:0] imag_out;

    // The sequencer owns the handshake on the input side and all memory addressing.
    hic_ctrl #(
        .TAPS  (TAPS),
        .DELAY (DELAY)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_sample   ($signed(s_axis_tdata)),
        .o_we       (mem_we),
        .o_waddr    (mem_waddr),
        .o_wdata    (mem_wdata),
        .o_re       (mem_re),
        .o_raddr    (mem_raddr),
        .o_tag      (rd_tag),
        .o_mac      (mac_ctl),
        .i_out_busy (out_busy)
    );

    // One ring holds the history for both the FIR and the delay tap.
    hic_history_mem #(
        .TAPS (TAPS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    hic_mac #(
        .TAPS (TAPS)
    ) u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tag       (rd_tag),
        .i_ctl       (mac_ctl),
        .i_rdata     (mem_rdata),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_real      (real_out),
        .o_imag      (imag_out),
        .o_busy      (out_busy)
    );

    assign m_axis_tdata = {imag_out, real_out};

endmodule

FILE: hw/rtl/hic_history_mem.sv
// Sample history store: one write port, one read port with registered read data.
// Depends on hic_pkg for the sample width.
`timescale 1ns / 1ps

module hic_history_mem #(
    parameter int TAPS = hic_pkg::HIC_TAPS
) (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [$clog2(TAPS)-1:0]             i_waddr,
    input  logic signed [hic_pkg::SAMPLE_W-1:0] i_wdata,
    input  logic                                i_re,
    input  logic [$clog2(TAPS)-1:0]             i_raddr,
    output logic signed [hic_pkg::SAMPLE_W-1:0] o_rdata
);
    import hic_pkg::*;

    logic signed [SAMPLE_W-1:0] mem [TAPS];
    logic signed [SAMPLE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/hic_mac.sv
// Shared multiply-accumulate datapath, rounding, saturation and the output word register.
// Depends on hic_pkg for the read tag, control struct and widths.
`timescale 1ns / 1ps

module hic_mac #(
    parameter int TAPS = hic_pkg::HIC_TAPS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  hic_pkg::t_rd_tag                    i_tag,
    input  hic_pkg::t_mac_ctl                   i_ctl,
    input  logic signed [hic_pkg::SAMPLE_W-1:0] i_rdata,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic signed [hic_pkg::SAMPLE_W-1:0] o_real,
    output logic signed [hic_pkg::SAMPLE_W-1:0] o_imag,
    output logic                                o_busy
);
    import hic_pkg::*;

    localparam int ACC_W = PROD_W + $clog2(TAPS);
    localparam int Y_W   = ACC_W + 1 - ROUND_SH;

    logic                       r_t1_delay;
    logic                       r_t1_tap;
    logic signed [SAMPLE_W-1:0] r_coef;
    logic signed [PROD_W-1:0]   r_prod;
    logic                       r_t2_tap;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [SAMPLE_W-1:0] r_real;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_real_out;
    logic signed [SAMPLE_W-1:0] r_imag_out;

    logic signed [ACC_W:0]      biased;
    logic signed [Y_W-1:0]      y;
    logic signed [SAMPLE_W-1:0] imag_sat;

    // Round half up: add half an LSB of Q1.15, then drop fifteen bits arithmetically.
    always_comb begin
        biased = {r_acc[ACC_W-1], r_acc} + (ACC_W + 1)'(1 << (ROUND_SH - 1));
        y      = biased[ACC_W:ROUND_SH];
        if (y[Y_W-1:SAMPLE_W-1] == {(Y_W - SAMPLE_W + 1){y[SAMPLE_W-1]}}) begin
            imag_sat = y[SAMPLE_W-1:0];
        end else if (y[Y_W-1]) begin
            imag_sat = {1'b1, {(SAMPLE_W - 1){1'b0}}};
        end else begin
            imag_sat = {1'b0, {(SAMPLE_W - 1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        r_coef <= i_tag.coef;
        r_prod <= i_rdata * r_coef;
        if (r_t1_delay) begin
            r_real <= i_rdata;
        end
        if (i_ctl.start) begin
            r_acc <= '0;
        end else if (r_t2_tap) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
        if (i_ctl.finish) begin
            r_real_out <= r_real;
            r_imag_out <= imag_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1_delay  <= 1'b0;
            r_t1_tap    <= 1'b0;
            r_t2_tap    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_t1_delay <= i_tag.is_delay;
            r_t1_tap   <= i_tag.is_tap;
            r_t2_tap   <= r_t1_tap;
            if (i_ctl.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_real      = r_real_out;
    assign o_imag      = r_imag_out;
    assign o_busy      = r_out_valid && !i_out_ready;

    // No product may still be in flight when a new sum starts or a result is taken.
    a_no_tap_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.start |-> !r_t1_tap && !r_t2_tap)
        else $error("tap product in flight at start of a new sum");
    a_no_tap_at_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.finish |-> !r_t1_tap && !r_t2_tap)
        else $error("result taken before the last product was summed");

endmodule

FILE: hw/rtl/hic_ctrl.sv
// Sequencer: reset clearing pass, sample write, delay read and the odd-tap read sweep.
// Depends on hic_pkg for the state type, structs and the tap function.
`timescale 1ns / 1ps

module hic_ctrl #(
    parameter int TAPS  = hic_pkg::HIC_TAPS,
    parameter int DELAY = hic_pkg::HIC_DELAY
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [hic_pkg::SAMPLE_W-1:0] i_sample,
    output logic                                o_we,
    output logic [$clog2(TAPS)-1:0]             o_waddr,
    output logic signed [hic_pkg::SAMPLE_W-1:0] o_wdata,
    output logic                                o_re,
    output logic [$clog2(TAPS)-1:0]             o_raddr,
    output hic_pkg::t_rd_tag                    o_tag,
    output hic_pkg::t_mac_ctl                   o_mac,
    input  logic                                i_out_busy
);
    import hic_pkg::*;

    localparam int K_W     = $clog2(TAPS);
    localparam int CENTER  = (TAPS - 1) / 2;
    localparam int FIRST_K = (CENTER % 2 == 1) ? 0 : 1;
    localparam int LAST_K  = FIRST_K + ((TAPS - 1 - FIRST_K) / 2) * 2;
    localparam int DMOD    = DELAY % TAPS;

    typedef logic signed [SAMPLE_W-1:0] t_tap_rom [TAPS];

    function automatic t_tap_rom build_rom();
        t_tap_rom rom;
        for (int i = 0; i < TAPS; i++) begin
            rom[i] = hic_tap_value(i, TAPS);
        end
        return rom;
    endfunction

    localparam t_tap_rom TAP_ROM = build_rom();

    // Ring address a - d, with d below TAPS.
    function automatic logic [K_W-1:0] ring_sub(input logic [K_W-1:0] a, input logic [K_W:0] d);
        logic [K_W:0] ax;
        ax = {1'b0, a};
        if (ax >= d) begin
            return K_W'(ax - d);
        end
        return K_W'(ax + (K_W + 1)'(TAPS) - d);
    endfunction

    t_state         r_state, n_state;
    logic [K_W-1:0] r_clr, n_clr;
    logic [K_W-1:0] r_pos, n_pos;
    logic [K_W-1:0] r_addr, n_addr;
    logic [K_W-1:0] r_k, n_k;
    logic           r_drain, n_drain;
    logic           accept;

    assign accept = (r_state == S_IDLE) && i_valid;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:  if (r_clr == K_W'(TAPS - 1)) n_state = S_IDLE;
            S_IDLE:   if (i_valid) n_state = S_DELAY;
            S_DELAY:  n_state = S_TAP;
            S_TAP:    if (r_k == K_W'(LAST_K)) n_state = S_DRAIN;
            S_DRAIN:  if (r_drain) n_state = S_FINISH;
            S_FINISH: if (!i_out_busy) n_state = S_IDLE;
            default:  n_state = S_CLEAR;
        endcase
    end

    // Counters and addresses.
    always_comb begin
        n_clr   = r_clr;
        n_pos   = r_pos;
        n_addr  = r_addr;
        n_k     = r_k;
        n_drain = 1'b0;
        case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + 1'b1;
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_addr = ring_sub(r_pos, (K_W + 1)'(DMOD));
                end
            end
            S_DELAY: begin
                n_addr = ring_sub(r_pos, (K_W + 1)'(FIRST_K));
                n_k    = K_W'(FIRST_K);
            end
            S_TAP: begin
                n_addr = ring_sub(r_addr, (K_W + 1)'(2));
                n_k    = r_k + K_W'(2);
            end
            S_DRAIN: begin
                n_drain = !r_drain;
            end
            S_FINISH: begin
                if (!i_out_busy) begin
                    n_pos = (r_pos == K_W'(TAPS - 1)) ? '0 : r_pos + 1'b1;
                end
            end
            default: begin
                n_clr = '0;
            end
        endcase
    end

    // Outputs.
    always_comb begin
        o_ready      = (r_state == S_IDLE);
        o_we         = 1'b0;
        o_waddr      = r_pos;
        o_wdata      = i_sample;
        o_re         = 1'b0;
        o_raddr      = r_addr;
        o_tag        = '0;
        o_mac.start  = accept;
        o_mac.finish = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_we    = 1'b1;
                o_waddr = r_clr;
                o_wdata = '0;
            end
            S_IDLE: begin
                o_we = i_valid;
            end
            S_DELAY: begin
                o_re           = 1'b1;
                o_tag.is_delay = 1'b1;
            end
            S_TAP: begin
                o_re         = 1'b1;
                o_tag.is_tap = 1'b1;
                o_tag.coef   = TAP_ROM[r_k];
            end
            S_FINISH: begin
                o_mac.finish = !i_out_busy;
            end
            default: begin
                o_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_pos   <= '0;
            r_drain <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_pos   <= n_pos;
            r_drain <= n_drain;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_k    <= n_k;
    end

    a_k_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TAP) |-> (r_k <= K_W'(LAST_K)))
        else $error("tap index beyond the last odd tap");
    a_sweep_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TAP && r_k == K_W'(LAST_K)) |=> (r_state == S_DRAIN))
        else $error("tap sweep did not end at the last tap");
    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_DELAY))
        else $error("accepted sample did not start the delay read");
    a_finish_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == S_FINISH) |-> ($past(r_state) == S_DRAIN))
        else $error("result stage entered without draining the pipeline");

endmodule
